@@ hdl/srb_pkg.sv @@
`timescale 1ns / 1ps
package srb_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int TAG_BITS  = 16;
	localparam int SEQ_W     = 32;
	localparam int CAP_W     = 5;
	localparam int CAP_RESET = 16;
	localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	typedef enum logic [1:0] {
		DISP_DELIVERED = 2'd0,
		DISP_FORCED    = 2'd1,
		DISP_DUPLICATE = 2'd2,
		DISP_STALE     = 2'd3
	} disp_t;

	typedef struct packed {
		logic signed [SEQ_W-1:0] seq_number;
		logic [TAG_BITS-1:0]     packet_tag;
	} packet_t;

	typedef struct packed {
		logic signed [SEQ_W-1:0] out_seq_number;
		logic [TAG_BITS-1:0]     out_tag;
		disp_t                   disposition;
		logic                    last_of_run;
	} result_t;

	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [TAG_BITS-1:0] tag;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FORCE_RD,
		ST_FORCE_CHK,
		ST_INS_RD,
		ST_INS_CMP,
		ST_DRN_RD,
		ST_DRN_CHK,
		ST_FINISH
	} state_t;

endpackage

@@ hdl/sequence_reorder_buffer_top.sv @@
`timescale 1ns / 1ps
// Packet resequencing buffer.
// A packet beat (seq_number, packet_tag) is taken on a clock edge with start high
// and busy low. The packet is inserted into a slot buffer sorted by signed
// sequence number (ties go after older entries). If the buffer already holds
// capacity entries, the smallest one is forced out first. The head is then
// drained: stale or repeated numbers are dropped, the next expected number is
// delivered, and the walk stops at the first gap.
// Every entry that leaves gives one result beat, shown for exactly one cycle
// with result_valid; the final beat of a packet carries last_of_run. The
// receiver cannot stall, and the last result of a packet appears before busy falls.
// Busy covers a forced entry, each slot shifted during the insert, placing the
// packet, each drained entry and the end of the walk, the finish state and the
// final result beat. The slot RAM has one read and one write port, and every
// compare takes a read state plus a check state.
// The capacity register is written through cfg_valid/cfg_data (always ready);
// the user must write it only while the block is idle, which the block itself
// does not enforce; 0 acts as 1, values above 16 act as 16.
// Reset empties the buffer, clears the first-packet flag and sets capacity 16.
module sequence_reorder_buffer_top
	import srb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  packet_t          packet,
	output logic             result_valid,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	state_t              state_q, state_d;
	packet_t             pkt_q, pkt_d;
	logic [CAP_W-1:0]    cap_q;
	logic [SEQ_W-1:0]    last_q, last_d;
	logic                started_q, started_d;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [SLOT_AW-1:0]  head_q, head_d;
	logic [CNT_W-1:0]    pos_q, pos_d;
	logic                pend_valid_q, pend_valid_d;
	result_t             pend_q, pend_d;
	logic                res_valid_q, res_valid_d;
	result_t             res_q, res_d;

	logic                ram_we;
	logic [SLOT_AW-1:0]  ram_waddr, ram_raddr;
	slot_t               ram_wdata, ram_rdata;

	logic [CMP_W-1:0]    cap_eff;
	logic [SEQ_W-1:0]    cmp_b;
	logic [SEQ_W:0]      diff;
	logic                a_greater;
	logic                produce, flush;
	disp_t               prod_disp;

	// logical slot index to RAM address, relative to the head
	function automatic logic [SLOT_AW-1:0] phys(input logic [SLOT_AW-1:0] head,
		input logic [CNT_W-1:0] idx);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
		if (sum >= (CNT_W + 1)'(MAX_SLOTS)) begin
			sum = sum - (CNT_W + 1)'(MAX_SLOTS);
		end
		return sum[SLOT_AW-1:0];
	endfunction

	srb_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(MAX_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_SLOTS)) begin
			cap_eff = CMP_W'(MAX_SLOTS);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end

	// shared subtractor: wrapped difference for force and drain checks, signed compare for insert
	assign cmp_b     = (state_q == ST_INS_CMP) ? pkt_q.seq_number : last_q;
	assign diff      = {ram_rdata.seq[SEQ_W-1], ram_rdata.seq} - {cmp_b[SEQ_W-1], cmp_b};
	assign a_greater = !diff[SEQ_W] && (diff != '0);

	always_comb begin
		state_d      = state_q;
		pkt_d        = pkt_q;
		last_d       = last_q;
		started_d    = started_q;
		fill_d       = fill_q;
		head_d       = head_q;
		pos_d        = pos_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		res_valid_d  = 1'b0;
		res_d        = res_q;
		ram_we       = 1'b0;
		ram_waddr    = phys(head_q, pos_q);
		ram_wdata    = ram_rdata;
		ram_raddr    = head_q;
		produce      = 1'b0;
		flush        = 1'b0;
		prod_disp    = DISP_DELIVERED;

		case (state_q)
			ST_IDLE: begin
				// the final beat of the previous packet still holds busy high
				if (start && !busy) begin
					pkt_d = packet;
					if (!started_q) begin
						last_d    = packet.seq_number - SEQ_W'(1);
						started_d = 1'b1;
					end
					pos_d = fill_q;
					if (CMP_W'(fill_q) >= cap_eff && fill_q != '0) begin
						state_d = ST_FORCE_RD;
					end else begin
						state_d = ST_INS_RD;
					end
				end
			end
			ST_FORCE_RD: begin
				ram_raddr = head_q;
				state_d   = ST_FORCE_CHK;
			end
			ST_FORCE_CHK: begin
				produce = 1'b1;
				if (diff[SEQ_W-1:0] != '0 && !diff[SEQ_W-1]) begin
					prod_disp = DISP_FORCED;
					last_d    = ram_rdata.seq;
				end else begin
					prod_disp = DISP_STALE;
				end
				head_d  = (head_q == SLOT_AW'(MAX_SLOTS - 1)) ? '0 : head_q + SLOT_AW'(1);
				fill_d  = fill_q - CNT_W'(1);
				pos_d   = fill_q - CNT_W'(1);
				state_d = ST_INS_RD;
			end
			ST_INS_RD: begin
				if (pos_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, pos_q);
					ram_wdata = {pkt_q.seq_number, pkt_q.packet_tag};
					fill_d    = fill_q + CNT_W'(1);
					state_d   = ST_DRN_RD;
				end else begin
					ram_raddr = phys(head_q, pos_q - CNT_W'(1));
					state_d   = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, pos_q);
				if (a_greater) begin
					ram_wdata = ram_rdata;
					pos_d     = pos_q - CNT_W'(1);
					state_d   = ST_INS_RD;
				end else begin
					ram_wdata = {pkt_q.seq_number, pkt_q.packet_tag};
					fill_d    = fill_q + CNT_W'(1);
					state_d   = ST_DRN_RD;
				end
			end
			ST_DRN_RD: begin
				ram_raddr = head_q;
				state_d   = (fill_q == '0) ? ST_FINISH : ST_DRN_CHK;
			end
			ST_DRN_CHK: begin
				if (diff[SEQ_W-1:0] == '0 || diff[SEQ_W-1]) begin
					produce   = 1'b1;
					prod_disp = DISP_DUPLICATE;
				end else if (diff[SEQ_W-1:0] == SEQ_W'(1)) begin
					produce   = 1'b1;
					prod_disp = DISP_DELIVERED;
					last_d    = ram_rdata.seq;
				end
				if (produce) begin
					head_d  = (head_q == SLOT_AW'(MAX_SLOTS - 1)) ? '0 : head_q + SLOT_AW'(1);
					fill_d  = fill_q - CNT_W'(1);
					state_d = ST_DRN_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				flush   = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// one result is held back so the final beat of a packet can be flagged
		if (produce) begin
			if (pend_valid_q) begin
				res_valid_d = 1'b1;
				res_d       = pend_q;
			end
			pend_valid_d          = 1'b1;
			pend_d.out_seq_number = ram_rdata.seq;
			pend_d.out_tag        = ram_rdata.tag;
			pend_d.disposition    = prod_disp;
			pend_d.last_of_run    = 1'b0;
		end else if (flush && pend_valid_q) begin
			res_valid_d       = 1'b1;
			res_d             = pend_q;
			res_d.last_of_run = 1'b1;
			pend_valid_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_W'(CAP_RESET);
			last_q       <= '0;
			started_q    <= 1'b0;
			fill_q       <= '0;
			head_q       <= '0;
			pos_q        <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			last_q       <= last_d;
			started_q    <= started_d;
			fill_q       <= fill_d;
			head_q       <= head_d;
			pos_q        <= pos_d;
			pend_valid_q <= pend_valid_d;
			res_valid_q  <= res_valid_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		pkt_d_reg: begin
			pkt_q  <= pkt_d;
			pend_q <= pend_d;
			res_q  <= res_d;
		end
	end

	assign busy         = (state_q != ST_IDLE) || pend_valid_q || res_valid_q;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ hdl/srb_ram.sv @@
`timescale 1ns / 1ps
module srb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/srb_checker.sv @@
`timescale 1ns / 1ps
module srb_checker
	import srb_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	// a taken packet keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after a packet beat");

	// results only appear while a packet is in progress
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result beat while not busy");

	// a non-final beat leaves the block busy, as more beats of the same packet follow
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_run |=> busy)
		else $error("run ended without a final beat");

	// the final beat is never directly followed by another result
	a_run_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_of_run |=> !result_valid)
		else $error("result beat right after the final beat of a run");

endmodule

bind sequence_reorder_buffer_top srb_checker u_srb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.result      (result)
);
